// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port checker of the pooling block.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define SEQP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds across reset.
`define SEQP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== rtl/seqp_pkg.sv =====
// Types, constants and the saturation helper of the sequence pooling block.
// Used by every module of the block; depends on nothing.
package seqp_pkg;

   localparam int FEATURE_WIDTH = 64;
   localparam int ROW_LIMIT     = 65536;
   localparam int DATA_BITS     = 16;

   localparam int COL_BITS      = $clog2(FEATURE_WIDTH);
   localparam int COL_PORT_BITS = 6;
   localparam int VAL_BITS      = 16;
   localparam int ROW_BITS      = 16;
   localparam int OUT_BITS      = 16;
   localparam int BEST_BITS     = 17;
   localparam int ACC_BITS      = 32;
   localparam int CNT_BITS      = ROW_BITS + 1;
   localparam int QUO_BITS      = DATA_BITS;

   localparam int MODE_BITS     = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int REG_LSB       = 2;

   localparam logic [MODE_BITS-1:0] MODE_MAX   = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_LAST  = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_FIRST = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_SUM   = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_AVG   = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_SQRT  = 3'd5;

   localparam logic REG_POOL_MODE = 1'b0;
   localparam logic REG_PAD_VALUE = 1'b1;

   localparam logic signed [BEST_BITS-1:0] BEST_ROW_EMPTY = '1;

   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   localparam longint SAT_MAG = longint'(1) <<< (DATA_BITS - 1);
   localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'(SAT_MAG - longint'(1));
   localparam logic signed [ACC_BITS-1:0] SAT_LO = ACC_BITS'(-SAT_MAG);

   typedef struct packed {
      logic [MODE_BITS-1:0]       pool_mode;
      logic signed [VAL_BITS-1:0] pad_value;
   } cfg_type;

   typedef struct packed {
      logic signed [ACC_BITS-1:0] acc;
      logic [ROW_BITS-1:0]        best;
   } col_entry_type;

   typedef struct packed {
      logic                en;
      logic [COL_BITS-1:0] addr;
      col_entry_type       data;
   } col_wr_type;

   typedef struct packed {
      logic                       start;
      logic                       is_root;
      logic signed [ACC_BITS-1:0] acc;
      logic [CNT_BITS-1:0]        count;
   } math_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [OUT_BITS-1:0] result;
   } math_rsp_type;

   // Clamp to the signed DATA_BITS range and hand back the output width.
   function automatic logic signed [OUT_BITS-1:0] sat_out(
      input logic signed [ACC_BITS-1:0] v);
      logic signed [ACC_BITS-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end else begin
         r = v;
      end
      return r[OUT_BITS-1:0];
   endfunction

endpackage

// ===== rtl/seqp_col_mem.sv =====
// Per-column state memory: accumulator and best row, one entry per column.
// Synchronous write, registered read; uses seqp_pkg types.
module seqp_col_mem (
   input  logic                             clock,
   input  seqp_pkg::col_wr_type             wr,
   input  logic                             rd_en,
   input  logic [seqp_pkg::COL_BITS-1:0]    rd_addr,
   output seqp_pkg::col_entry_type          rd_data
);

   seqp_pkg::col_entry_type col_mem_ff [seqp_pkg::FEATURE_WIDTH];
   seqp_pkg::col_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         col_mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= col_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/seqp_root_div.sv =====
// Shared iterative unit for AVERAGE (sum / count) and SQRT (sum / sqrt(count)).
// Builds a saturating quotient one bit per cycle; uses seqp_pkg types and sat_out.
module seqp_root_div (
   input  logic                   clock,
   input  logic                   reset,
   input  seqp_pkg::math_req_type req,
   output seqp_pkg::math_rsp_type rsp
);

   localparam int MAG_W = seqp_pkg::ACC_BITS;
   localparam int CNT_W = seqp_pkg::CNT_BITS;
   localparam int Q_W   = seqp_pkg::QUO_BITS;
   localparam int K_W   = $clog2(Q_W);
   localparam int QC_W  = Q_W + CNT_W - 1;
   localparam int LIN_W = QC_W + 1;
   localparam int SQC_W = 2 * Q_W + CNT_W - 1;
   localparam int SQ_W  = SQC_W + 2;
   localparam int TGT_W = 2 * MAG_W - 1;

   localparam logic [1:0] M_IDLE = 2'd0;
   localparam logic [1:0] M_PREP = 2'd1;
   localparam logic [1:0] M_STEP = 2'd2;
   localparam logic [1:0] M_DONE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic             done_ff, done_in;
   logic             neg_ff, root_ff;
   logic [MAG_W-1:0] mag_ff;
   logic [CNT_W-1:0] count_ff;
   logic [TGT_W-1:0] target_ff;
   logic [Q_W-1:0]   q_ff;
   logic [QC_W-1:0]  qc_ff;
   logic [SQC_W-1:0] sqc_ff;
   logic [K_W-1:0]   k_ff;
   logic signed [seqp_pkg::OUT_BITS-1:0] res_ff;

   logic [MAG_W-1:0]   mag_start;
   logic [2*MAG_W-1:0] mag_sq;
   logic [LIN_W-1:0]   trial_lin;
   logic [SQ_W-1:0]    trial_sq;
   logic               fits;
   logic signed [MAG_W-1:0] q_ext, q_signed;

   assign mag_start = req.acc[MAG_W-1] ? MAG_W'(~req.acc + 1'b1) : MAG_W'(req.acc);
   assign mag_sq    = mag_ff * mag_ff;

   // t = q + 2^k: t*count and t*t*count from the running products
   assign trial_lin = LIN_W'(qc_ff) + (LIN_W'(count_ff) << k_ff);
   assign trial_sq  = SQ_W'(sqc_ff) + ((SQ_W'(qc_ff) << 1) << k_ff)
                    + (SQ_W'(count_ff) << {k_ff, 1'b0});
   assign fits      = root_ff ? (TGT_W'(trial_sq) <= target_ff)
                              : (TGT_W'(trial_lin) <= target_ff);

   assign q_ext    = MAG_W'(q_ff);
   assign q_signed = neg_ff ? -q_ext : q_ext;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      case (state_ff)
         M_IDLE: begin
            if (req.start) begin
               state_in = M_PREP;
            end
         end
         M_PREP: begin
            state_in = M_STEP;
         end
         M_STEP: begin
            if (k_ff == '0) begin
               state_in = M_DONE;
            end
         end
         M_DONE: begin
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         M_IDLE: begin
            neg_ff   <= req.acc[MAG_W-1];
            mag_ff   <= mag_start;
            count_ff <= req.count;
            root_ff  <= req.is_root;
            q_ff     <= '0;
            qc_ff    <= '0;
            sqc_ff   <= '0;
            k_ff     <= K_W'(Q_W - 1);
         end
         M_PREP: begin
            target_ff <= root_ff ? TGT_W'(mag_sq) : TGT_W'(mag_ff);
         end
         M_STEP: begin
            if (fits) begin
               q_ff   <= q_ff | (Q_W'(1) << k_ff);
               qc_ff  <= trial_lin[QC_W-1:0];
               sqc_ff <= trial_sq[SQC_W-1:0];
            end
            k_ff <= k_ff - 1'b1;
         end
         M_DONE: begin
            res_ff <= seqp_pkg::sat_out(q_signed);
         end
         default: begin
            k_ff <= k_ff;
         end
      endcase
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

// ===== rtl/seqp_csr.sv =====
// Configuration registers of the pooling block: pool mode and pad value.
// APB-style access, always ready; uses seqp_pkg register codes and types.
module seqp_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [seqp_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [seqp_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [seqp_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready,
   output seqp_pkg::cfg_type                    cfg
);

   logic [seqp_pkg::MODE_BITS-1:0]       pool_mode_ff, pool_mode_in;
   logic signed [seqp_pkg::VAL_BITS-1:0] pad_value_ff, pad_value_in;
   logic                                 wr_en;

   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      pool_mode_in = pool_mode_ff;
      pad_value_in = pad_value_ff;
      if (wr_en) begin
         case (paddr[seqp_pkg::REG_LSB])
            seqp_pkg::REG_POOL_MODE: pool_mode_in = pwdata[seqp_pkg::MODE_BITS-1:0];
            seqp_pkg::REG_PAD_VALUE: pad_value_in = pwdata[seqp_pkg::VAL_BITS-1:0];
            default: pool_mode_in = pool_mode_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[seqp_pkg::REG_LSB])
         seqp_pkg::REG_POOL_MODE: prdata = seqp_pkg::CSR_DATA_BITS'(pool_mode_ff);
         seqp_pkg::REG_PAD_VALUE: prdata = seqp_pkg::CSR_DATA_BITS'(pad_value_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_mode_ff <= seqp_pkg::MODE_MAX;
         pad_value_ff <= '0;
      end else begin
         pool_mode_ff <= pool_mode_in;
         pad_value_ff <= pad_value_in;
      end
   end

   assign cfg.pool_mode = pool_mode_ff;
   assign cfg.pad_value = pad_value_ff;

endmodule

// ===== rtl/sequence_pooling.sv =====
// Column-wise sequence pooling. One request at a time: a request is taken, its column
// entry is read, then updated and written back, and a last row then queues its result.
// Empty slots skip the column memory and queue the pad value; AVERAGE/SQRT last rows
// first pass through the 16-step quotient unit. Out-of-range columns are dropped.
// Reset clears control, mode, pad value and row count; the column memory is not cleared.
module sequence_pooling (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic signed [seqp_pkg::VAL_BITS-1:0]        req_value,
   input  logic [seqp_pkg::COL_PORT_BITS-1:0]          req_column,
   input  logic [seqp_pkg::ROW_BITS-1:0]               req_row_position,
   input  logic                                        req_first_row,
   input  logic                                        req_last_row,
   input  logic                                        req_empty_seq,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [seqp_pkg::OUT_BITS-1:0]        rsp_pooled_value,
   output logic signed [seqp_pkg::BEST_BITS-1:0]       rsp_best_row,
   output logic [seqp_pkg::COL_PORT_BITS-1:0]          rsp_out_column,
   input  logic                                        psel,
   input  logic                                        penable,
   input  logic                                        pwrite,
   input  logic [seqp_pkg::CSR_ADDR_BITS-1:0]          paddr,
   input  logic [seqp_pkg::CSR_DATA_BITS-1:0]          pwdata,
   output logic [seqp_pkg::CSR_DATA_BITS-1:0]          prdata,
   output logic                                        pready
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_UPDATE = 2'd1;
   localparam logic [1:0] ST_MATH   = 2'd2;
   localparam logic [1:0] ST_OUT    = 2'd3;

   localparam int ACC_W  = seqp_pkg::ACC_BITS;
   localparam int ROW_W  = seqp_pkg::ROW_BITS;
   localparam int BEST_W = seqp_pkg::BEST_BITS;

   seqp_pkg::cfg_type       cfg;
   seqp_pkg::col_wr_type    col_wr;
   seqp_pkg::col_entry_type col_rd;
   seqp_pkg::math_req_type  math_req;
   seqp_pkg::math_rsp_type  math_rsp;

   logic [1:0]     state_ff, state_in;
   logic [ROW_W-1:0] rows_ff, rows_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic signed [seqp_pkg::VAL_BITS-1:0]  val_ff, val_in;
   logic [seqp_pkg::COL_PORT_BITS-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]                      row_ff, row_in;
   logic                                  first_ff, first_in;
   logic                                  last_ff, last_in;

   logic signed [seqp_pkg::OUT_BITS-1:0]  pend_value_ff, pend_value_in;
   logic signed [BEST_W-1:0]              pend_best_ff, pend_best_in;
   logic [seqp_pkg::COL_PORT_BITS-1:0]    pend_col_ff, pend_col_in;
   logic signed [seqp_pkg::OUT_BITS-1:0]  rsp_value_ff, rsp_value_in;
   logic signed [BEST_W-1:0]              rsp_best_ff, rsp_best_in;
   logic [seqp_pkg::COL_PORT_BITS-1:0]    rsp_col_ff, rsp_col_in;

   logic                           accept;
   logic                           col_in_range;
   logic [seqp_pkg::MODE_BITS-1:0] mode;
   logic signed [ACC_W-1:0]        v_ext;
   logic signed [ACC_W:0]          sum_wide;
   logic signed [ACC_W-1:0]        sum_sat;
   logic signed [ACC_W-1:0]        acc_new;
   logic [ROW_W-1:0]               best_new;
   logic [ROW_W-1:0]               rows_new;
   logic                           needs_math;

   seqp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   seqp_col_mem u_mem (
      .clock   (clock),
      .wr      (col_wr),
      .rd_en   (accept),
      .rd_addr (req_column[seqp_pkg::COL_BITS-1:0]),
      .rd_data (col_rd)
   );

   seqp_root_div u_math (
      .clock (clock),
      .reset (reset),
      .req   (math_req),
      .rsp   (math_rsp)
   );

   assign req_stall    = (state_ff != ST_IDLE);
   assign accept       = req_valid && !req_stall;
   assign col_in_range = ({1'b0, req_column} < (seqp_pkg::COL_PORT_BITS + 1)'(seqp_pkg::FEATURE_WIDTH));

   // unused mode codes fall back to SUM
   assign mode = (cfg.pool_mode > seqp_pkg::MODE_SQRT) ? seqp_pkg::MODE_SUM : cfg.pool_mode;

   assign v_ext    = ACC_W'(val_ff);
   assign sum_wide = (ACC_W + 1)'(col_rd.acc) + (ACC_W + 1)'(v_ext);
   assign sum_sat  = (sum_wide[ACC_W] != sum_wide[ACC_W-1])
                   ? (sum_wide[ACC_W] ? seqp_pkg::ACC_MIN : seqp_pkg::ACC_MAX)
                   : sum_wide[ACC_W-1:0];

   always_comb begin
      acc_new  = col_rd.acc;
      best_new = col_rd.best;
      if (first_ff) begin
         acc_new  = v_ext;
         best_new = row_ff;
      end else begin
         case (mode)
            seqp_pkg::MODE_MAX: begin
               if (v_ext > col_rd.acc) begin
                  acc_new  = v_ext;
                  best_new = row_ff;
               end
            end
            seqp_pkg::MODE_LAST:  acc_new = v_ext;
            seqp_pkg::MODE_FIRST: acc_new = col_rd.acc;
            default:              acc_new = sum_sat;
         endcase
      end
   end

   // row count minus one, advanced by column 0 only
   always_comb begin
      rows_new = rows_ff;
      if (col_ff == '0) begin
         if (first_ff) begin
            rows_new = '0;
         end else if (rows_ff < ROW_W'(seqp_pkg::ROW_LIMIT - 1)) begin
            rows_new = rows_ff + 1'b1;
         end
      end
   end

   assign needs_math = (mode == seqp_pkg::MODE_AVG) || (mode == seqp_pkg::MODE_SQRT);

   assign col_wr.en        = (state_ff == ST_UPDATE);
   assign col_wr.addr      = col_ff[seqp_pkg::COL_BITS-1:0];
   assign col_wr.data.acc  = acc_new;
   assign col_wr.data.best = best_new;

   assign math_req.start   = (state_ff == ST_UPDATE) && last_ff && needs_math;
   assign math_req.is_root = (mode == seqp_pkg::MODE_SQRT);
   assign math_req.acc     = acc_new;
   assign math_req.count   = seqp_pkg::CNT_BITS'(rows_new) + 1'b1;

   always_comb begin
      state_in      = state_ff;
      rows_in       = rows_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      val_in        = val_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      pend_value_in = pend_value_ff;
      pend_best_in  = pend_best_ff;
      pend_col_in   = pend_col_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_best_in   = rsp_best_ff;
      rsp_col_in    = rsp_col_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               val_in   = req_value;
               col_in   = req_column;
               row_in   = req_row_position;
               first_in = req_first_row;
               last_in  = req_last_row;
               if (req_empty_seq) begin
                  pend_value_in = cfg.pad_value;
                  pend_best_in  = seqp_pkg::BEST_ROW_EMPTY;
                  pend_col_in   = req_column;
                  state_in      = ST_OUT;
               end else if (col_in_range) begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            rows_in     = rows_new;
            pend_col_in = col_ff;
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (needs_math) begin
               state_in = ST_MATH;
            end else begin
               pend_value_in = seqp_pkg::sat_out(acc_new);
               pend_best_in  = (mode == seqp_pkg::MODE_MAX) ? BEST_W'(best_new) : '0;
               state_in      = ST_OUT;
            end
         end
         ST_MATH: begin
            if (math_rsp.done) begin
               pend_value_in = math_rsp.result;
               pend_best_in  = '0;
               state_in      = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold the result until the output register frees up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = pend_value_ff;
               rsp_best_in  = pend_best_ff;
               rsp_col_in   = pend_col_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff        <= val_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      pend_value_ff <= pend_value_in;
      pend_best_ff  <= pend_best_in;
      pend_col_ff   <= pend_col_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_best_ff   <= rsp_best_in;
      rsp_col_ff    <= rsp_col_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pooled_value = rsp_value_ff;
   assign rsp_best_row     = rsp_best_ff;
   assign rsp_out_column   = rsp_col_ff;

endmodule

// ===== rtl/seqp_port_checker.sv =====
// Port-level checks for sequence_pooling, attached by the bind at the end of the file.
// Depends on assert_macros.svh and seqp_pkg.
`include "assert_macros.svh"

module seqp_port_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [seqp_pkg::OUT_BITS-1:0]  rsp_pooled_value,
   input logic signed [seqp_pkg::BEST_BITS-1:0] rsp_best_row,
   input logic [seqp_pkg::COL_PORT_BITS-1:0]    rsp_out_column
);

   `SEQP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pooled_value) && $stable(rsp_best_row) && $stable(rsp_out_column), "stalled result changed")

   `SEQP_ASSERT(a_one_at_a_time, clock, reset, req_valid && !req_stall |=> req_stall, "second request taken while one is in flight")

   `SEQP_ASSERT(a_best_row_code, clock, reset, rsp_valid && rsp_best_row[seqp_pkg::BEST_BITS-1] |-> rsp_best_row == seqp_pkg::BEST_ROW_EMPTY, "negative best row other than the empty mark")

   `SEQP_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid && !req_stall, "block not idle after reset")

endmodule

bind sequence_pooling seqp_port_checker u_port_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_pooled_value (rsp_pooled_value),
   .rsp_best_row     (rsp_best_row),
   .rsp_out_column   (rsp_out_column)
);

// ===== tb/seqp_checker.sv =====
// Checker for the sequence pooling block: tracks register writes and accepted requests,
// predicts every pooled result and compares it with what the block returns.
// Depends on seqp_pkg for widths, mode codes and register indexes.
`timescale 1ns / 100ps

module seqp_checker
   import seqp_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [VAL_BITS-1:0]    req_value,
   input  logic [COL_PORT_BITS-1:0]      req_column,
   input  logic [ROW_BITS-1:0]           req_row_position,
   input  logic                          req_first_row,
   input  logic                          req_last_row,
   input  logic                          req_empty_seq,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [OUT_BITS-1:0]    rsp_pooled_value,
   input  logic signed [BEST_BITS-1:0]   rsp_best_row,
   input  logic [COL_PORT_BITS-1:0]      rsp_out_column,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic                          pready,
   input  logic [CSR_ADDR_BITS-1:0]      paddr,
   input  logic [CSR_DATA_BITS-1:0]      pwdata,
   output int                            fail_count,
   output int                            pending
);

   typedef struct {
      logic signed [OUT_BITS-1:0]  pooled;
      logic signed [BEST_BITS-1:0] best;
      logic [COL_PORT_BITS-1:0]    column;
   } pooled_result_t;

   pooled_result_t             results_due [$];
   longint                     col_sum [FEATURE_WIDTH];
   logic [ROW_BITS-1:0]        col_peak_row [FEATURE_WIDTH];
   logic [ROW_BITS-1:0]        row_index;
   logic [MODE_BITS-1:0]       mode;
   logic signed [VAL_BITS-1:0] pad;
   int                         errors = 0;

   function automatic logic signed [OUT_BITS-1:0] clamp_data(input longint v);
      longint hi;
      hi = (longint'(1) <<< (DATA_BITS - 1)) - 1;
      if (v > hi) begin
         v = hi;
      end else if (v < -hi - 1) begin
         v = -hi - 1;
      end
      return OUT_BITS'(v);
   endfunction

   // Digit-by-digit integer square root, rounded down.
   function automatic longint unsigned floor_root(input longint unsigned t);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = longint'(1) << 62;
      while (bitv > t) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (t >= res + bitv) begin
            t   = t - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   task automatic flag(input string what);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, what);
   endtask

   task automatic pool_element(input logic signed [VAL_BITS-1:0] val,
                               input logic [COL_PORT_BITS-1:0] col,
                               input logic [ROW_BITS-1:0] row,
                               input logic first, input logic last, input logic empty);
      logic [MODE_BITS-1:0] m;
      longint               acc;
      longint               count;
      longint unsigned      mag;
      longint               root;
      pooled_result_t       r;
      m        = (mode > MODE_SQRT) ? MODE_SUM : mode;
      r.column = col;
      r.best   = '0;
      if (empty) begin
         r.pooled = pad;
         r.best   = BEST_ROW_EMPTY;
         results_due.push_back(r);
         return;
      end
      // row count follows column 0 only
      if (col == 0) begin
         if (first) begin
            row_index = '0;
         end else if (row_index < ROW_LIMIT - 1) begin
            row_index = row_index + 1'b1;
         end
      end
      if (first) begin
         col_sum[col]      = longint'(val);
         col_peak_row[col] = row;
      end else begin
         case (m)
            MODE_MAX: begin
               if (longint'(val) > col_sum[col]) begin
                  col_sum[col]      = longint'(val);
                  col_peak_row[col] = row;
               end
            end
            MODE_LAST:  col_sum[col] = longint'(val);
            MODE_FIRST: ;
            default: begin
               acc = col_sum[col] + longint'(val);
               if (acc > longint'(ACC_MAX)) acc = longint'(ACC_MAX);
               if (acc < longint'(ACC_MIN)) acc = longint'(ACC_MIN);
               col_sum[col] = acc;
            end
         endcase
      end
      if (!last) return;
      acc   = col_sum[col];
      count = longint'(row_index) + 1;
      case (m)
         MODE_MAX: begin
            r.pooled = clamp_data(acc);
            r.best   = {1'b0, col_peak_row[col]};
         end
         MODE_AVG: r.pooled = clamp_data(acc / count);
         MODE_SQRT: begin
            mag      = (acc < 0) ? -acc : acc;
            root     = longint'(floor_root((mag * mag) / count));
            r.pooled = clamp_data((acc < 0) ? -root : root);
         end
         default: r.pooled = clamp_data(acc);
      endcase
      results_due.push_back(r);
   endtask

   task automatic check_result();
      pooled_result_t exp;
      if (results_due.size() == 0) begin
         flag($sformatf("unexpected result: value %0d row %0d column %0d",
                        rsp_pooled_value, rsp_best_row, rsp_out_column));
         return;
      end
      exp = results_due.pop_front();
      if (rsp_pooled_value !== exp.pooled || rsp_best_row !== exp.best ||
          rsp_out_column !== exp.column) begin
         flag($sformatf("result mismatch: expected value %0d row %0d column %0d, got %0d %0d %0d",
                        exp.pooled, exp.best, exp.column,
                        rsp_pooled_value, rsp_best_row, rsp_out_column));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         results_due.delete();
         row_index = '0;
         mode      = MODE_MAX;
         pad       = '0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[REG_LSB] == REG_POOL_MODE) begin
               mode = pwdata[MODE_BITS-1:0];
            end else begin
               pad = pwdata[VAL_BITS-1:0];
            end
         end
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) begin
            pool_element(req_value, req_column, req_row_position,
                         req_first_row, req_last_row, req_empty_seq);
         end
      end
      fail_count <= errors;
      pending    <= results_due.size();
   end

endmodule

// ===== tb/tb_sequence_pooling.sv =====
// Top of the sequence pooling testbench: clock, reset, register writes and request stimulus.
// Instantiates the block and seqp_checker, which predicts and compares the results.
`timescale 1ns / 100ps

module tb_sequence_pooling;
   import seqp_pkg::*;

   localparam int RANDOM_ITEMS  = 500;
   localparam int PHASE_ITEMS   = 60;
   localparam int SETTLE_CYCLES = 30;
   localparam int HOLD_CYCLES   = 300;
   localparam int FLOOD_ITEMS   = 40;

   typedef struct {
      logic signed [VAL_BITS-1:0] value;
      logic [COL_PORT_BITS-1:0]   column;
      logic [ROW_BITS-1:0]        row;
      logic                       first;
      logic                       last;
      logic                       empty;
   } element_t;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_stall;
   logic signed [VAL_BITS-1:0]    req_value        = '0;
   logic [COL_PORT_BITS-1:0]      req_column       = '0;
   logic [ROW_BITS-1:0]           req_row_position = '0;
   logic                          req_first_row    = 1'b0;
   logic                          req_last_row     = 1'b0;
   logic                          req_empty_seq    = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall        = 1'b0;
   logic signed [OUT_BITS-1:0]    rsp_pooled_value;
   logic signed [BEST_BITS-1:0]   rsp_best_row;
   logic [COL_PORT_BITS-1:0]      rsp_out_column;
   logic                          psel             = 1'b0;
   logic                          penable          = 1'b0;
   logic                          pwrite           = 1'b0;
   logic [CSR_ADDR_BITS-1:0]      paddr            = '0;
   logic [CSR_DATA_BITS-1:0]      pwdata           = '0;
   logic [CSR_DATA_BITS-1:0]      prdata;
   logic                          pready;

   bit                            calm        = 1'b0;
   bit                            hold_off    = 1'b0;
   logic [FEATURE_WIDTH-1:0]      col_written = '0;
   int                            items_sent  = 0;
   int                            fail_count;
   int                            pending;

   sequence_pooling u_top (.*);

   seqp_checker u_checker (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Result side: random stalls, calm stretches, and one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 34);
         end
      end
   end

   function automatic element_t mk_element(input logic signed [VAL_BITS-1:0] v,
                                           input logic [COL_PORT_BITS-1:0] c,
                                           input logic [ROW_BITS-1:0] r,
                                           input logic f, input logic l, input logic em);
      element_t e;
      e.value  = v;
      e.column = c;
      e.row    = r;
      e.first  = f;
      e.last   = l;
      e.empty  = em;
      return e;
   endfunction

   function automatic logic signed [VAL_BITS-1:0] rand_value();
      int t;
      case ($urandom_range(9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2, 3, 4, 5: begin
            t = $urandom_range(2047);
            return VAL_BITS'(t - 1024);
         end
         default: return VAL_BITS'($urandom);
      endcase
   endfunction

   function automatic int pick_width();
      int p;
      p = $urandom_range(99);
      if (p < 75) return $urandom_range(1, 4);
      if (p < 95) return $urandom_range(5, 16);
      return FEATURE_WIDTH;
   endfunction

   task automatic offer(input element_t e);
      // never read a column entry that no first row has loaded
      if (!e.empty && !col_written[e.column]) e.first = 1'b1;
      if (!e.empty && e.first) col_written[e.column] = 1'b1;
      req_value        <= e.value;
      req_column       <= e.column;
      req_row_position <= e.row;
      req_first_row    <= e.first;
      req_last_row     <= e.last;
      req_empty_seq    <= e.empty;
      req_valid        <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (!calm && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic write_register(input logic idx, input logic [CSR_DATA_BITS-1:0] data);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= CSR_ADDR_BITS'(idx) << REG_LSB;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Drain every outstanding result, then let requests without a result finish.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_sequence(input int width, input int rows, input int cut);
      logic [ROW_BITS-1:0] base;
      base = ROW_BITS'($urandom);
      for (int r = 0; r < cut; r++) begin
         for (int c = 0; c < width; c++) begin
            offer(mk_element(rand_value(), COL_PORT_BITS'(c), base + ROW_BITS'(r),
                             r == 0, r == rows - 1, 1'b0));
         end
      end
   endtask

   task automatic run_empty(input int width);
      for (int c = 0; c < width; c++) begin
         offer(mk_element(rand_value(), COL_PORT_BITS'(c), ROW_BITS'($urandom),
                          1'($urandom), 1'($urandom), 1'b1));
      end
   endtask

   initial begin
      logic [MODE_BITS-1:0]       dir_modes [5];
      logic signed [VAL_BITS-1:0] dir_vals [5][3];
      int                         phase;
      int                         mark;
      int                         pick;
      int                         width;
      int                         rows;
      int                         start;

      dir_modes = '{MODE_LAST, MODE_FIRST, MODE_SUM, MODE_AVG, MODE_SQRT};
      dir_vals  = '{'{16'sd7, 16'sh8000, 16'sh7FFF},
                    '{16'sh8000, 16'sd7, 16'sh7FFF},
                    '{16'sh7FFF, 16'sh7FFF, 16'sd5},
                    '{-16'sd3, -16'sd4, 16'sd2},
                    '{16'sh8000, 16'sh8000, 16'sh8000}};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Max with ties, extremes, a one-row sequence at the top column, empty slots
      write_register(REG_PAD_VALUE, 32'hFFFF_8000);
      write_register(REG_POOL_MODE, CSR_DATA_BITS'(MODE_MAX));
      offer(mk_element(16'sd0, 6'd0, 16'd100, 1'b1, 1'b0, 1'b0));
      offer(mk_element(16'sd0, 6'd1, 16'd100, 1'b1, 1'b0, 1'b0));
      offer(mk_element(16'sd5, 6'd0, 16'd101, 1'b0, 1'b0, 1'b0));
      offer(mk_element(16'sh8000, 6'd1, 16'd101, 1'b0, 1'b0, 1'b0));
      offer(mk_element(16'sd5, 6'd0, 16'd102, 1'b0, 1'b1, 1'b0));
      offer(mk_element(16'sh7FFF, 6'd1, 16'hFFFF, 1'b0, 1'b1, 1'b0));
      offer(mk_element(16'sd123, 6'd63, 16'd0, 1'b1, 1'b1, 1'b0));
      offer(mk_element(-16'sd1, 6'd0, 16'd0, 1'b1, 1'b1, 1'b1));
      offer(mk_element(16'sd0, 6'd63, 16'hFFFF, 1'b0, 1'b0, 1'b1));

      // Three-row sequences in every other mode: saturation, negative truncation
      for (int i = 0; i < 5; i++) begin
         settle();
         write_register(REG_POOL_MODE, CSR_DATA_BITS'(dir_modes[i]));
         for (int r = 0; r < 3; r++) begin
            offer(mk_element(dir_vals[i][r], 6'd0, ROW_BITS'(200 + r), r == 0, r == 2, 1'b0));
         end
      end

      // Switch from sum to average in the middle of a sequence
      settle();
      write_register(REG_POOL_MODE, CSR_DATA_BITS'(MODE_SUM));
      offer(mk_element(16'sd100, 6'd0, 16'd300, 1'b1, 1'b0, 1'b0));
      settle();
      write_register(REG_POOL_MODE, CSR_DATA_BITS'(MODE_AVG));
      offer(mk_element(16'sd51, 6'd0, 16'd301, 1'b0, 1'b1, 1'b0));

      phase = 0;
      start = items_sent;
      while (items_sent < start + RANDOM_ITEMS) begin
         settle();
         if (phase < 8) begin
            write_register(REG_POOL_MODE, CSR_DATA_BITS'(phase));
         end else begin
            write_register(REG_POOL_MODE, CSR_DATA_BITS'($urandom_range(7)));
         end
         case ($urandom_range(3))
            0:       write_register(REG_PAD_VALUE, 32'h0000_7FFF);
            1:       write_register(REG_PAD_VALUE, 32'h0000_8000);
            default: write_register(REG_PAD_VALUE, $urandom);
         endcase
         if (phase == 2) begin
            // hold the result side while requests keep coming to back the block up
            hold_off = 1'b1;
            calm     = 1'b1;
            repeat (FLOOD_ITEMS) begin
               offer(mk_element(rand_value(), 6'd0, ROW_BITS'($urandom), 1'b1, 1'b1, 1'b0));
            end
         end
         calm = (phase == 5);
         mark = items_sent;
         while (items_sent < mark + PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               width = pick_width();
               if (width > 16) begin
                  rows = $urandom_range(1, 2);
               end else if ($urandom_range(19) == 0) begin
                  rows = $urandom_range(10, 40);
               end else begin
                  rows = $urandom_range(1, 6);
               end
               run_sequence(width, rows, rows);
            end else if (pick < 80) begin
               run_empty($urandom_range(1, 4));
            end else if (pick < 90) begin
               // drop the tail of a sequence
               width = $urandom_range(1, 4);
               rows  = $urandom_range(2, 6);
               run_sequence(width, rows, $urandom_range(1, rows - 1));
            end else begin
               offer(mk_element(rand_value(), COL_PORT_BITS'($urandom), ROW_BITS'($urandom),
                                1'($urandom), 1'($urandom), $urandom_range(9) == 0));
            end
         end
         calm = 1'b0;
         phase++;
      end

      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sequence_pooling.f =====
+incdir+rtl
rtl/seqp_pkg.sv
rtl/seqp_col_mem.sv
rtl/seqp_root_div.sv
rtl/seqp_csr.sv
rtl/sequence_pooling.sv
rtl/seqp_port_checker.sv
tb/seqp_checker.sv
tb/tb_sequence_pooling.sv
